/* hdl/efv_pkg.sv */
// Shared types and constants of the encoder FIR velocity filter.
`timescale 1ns / 1ps

package efv_pkg;

   // Filter length and fixed widths
   localparam int TAP_COUNT = 9;
   localparam int COEF_W    = 13;
   localparam int VEL_W     = 37;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [VEL_W-1:0]  vel_type;

   // Differentiator taps, newest sample first; they sum to zero
   localparam coef_type TAP_COEF [TAP_COUNT] = '{
      13'sd2727, 13'sd534, -13'sd2658, -13'sd795, 13'sd72,
      13'sd110, 13'sd19, -13'sd6, -13'sd3
   };

   // Control of the history cells for one transfer
   typedef struct packed {
      logic load;    // accept a new count this cycle
      logic prime;   // history is empty: fill every entry with the count
   } cell_ctrl_type;

   // Load enables of the two adder stages
   typedef struct packed {
      logic adv_group;
      logic adv_final;
   } tree_ctrl_type;

endpackage

/* hdl/efv_req_if.sv */
// Input channel: one encoder count per transfer.
`timescale 1ns / 1ps

interface efv_req_if #(
   parameter int COUNT_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [COUNT_WIDTH-1:0] encoder_count;

   modport source (output valid, output encoder_count, input ready);
   modport sink (input valid, input encoder_count, output ready);
endinterface

/* hdl/efv_rsp_if.sv */
// Result channel: position and velocity sum per transfer.
`timescale 1ns / 1ps

interface efv_rsp_if #(
   parameter int COUNT_WIDTH = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [COUNT_WIDTH-1:0] position_count;
   efv_pkg::vel_type              velocity_sum;

   modport source (output valid, output position_count, output velocity_sum, input ready);
   modport sink (input valid, input position_count, input velocity_sum, output ready);
endinterface

/* hdl/efv_tap_cell.sv */
// One history cell: holds one past count and forms its weighted product.
`timescale 1ns / 1ps

module efv_tap_cell #(
   parameter int                COUNT_WIDTH = 24,
   parameter efv_pkg::coef_type COEF        = 13'sd0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  efv_pkg::cell_ctrl_type        ctrl,
   input  logic signed [COUNT_WIDTH-1:0] count_in,
   input  logic signed [COUNT_WIDTH-1:0] link_in,
   output logic signed [COUNT_WIDTH-1:0] hist_out,
   output efv_pkg::vel_type              prod_out
);

   localparam int EXT_W = (COUNT_WIDTH + efv_pkg::COEF_W > efv_pkg::VEL_W) ?
                          COUNT_WIDTH + efv_pkg::COEF_W : efv_pkg::VEL_W;

   logic signed [COUNT_WIDTH-1:0] hist_ff, hist_in;
   efv_pkg::vel_type              prod_ff, prod_in;
   logic signed [EXT_W-1:0]       ext_count, ext_coef, full_prod;

   // Take the neighbor's entry, or the new count when priming
   assign hist_in = ctrl.prime ? count_in : link_in;

   // Weight the updated entry; the product wraps to the velocity width
   assign ext_count = EXT_W'(hist_in);
   assign ext_coef  = EXT_W'(COEF);
   assign full_prod = ext_count * ext_coef;
   assign prod_in   = full_prod[efv_pkg::VEL_W-1:0];

   // Hold history; clear it at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (ctrl.load) begin
         hist_ff <= hist_in;
      end
   end

   // Register the product for the adder stages
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   assign hist_out = hist_ff;
   assign prod_out = prod_ff;

endmodule

/* hdl/efv_sum_tree.sv */
// Two-stage registered adder tree over the tap products.
`timescale 1ns / 1ps

module efv_sum_tree (
   input  logic                   clock,
   input  efv_pkg::tree_ctrl_type ctrl,
   input  efv_pkg::vel_type       prod_in [efv_pkg::TAP_COUNT],
   output efv_pkg::vel_type       sum_out
);

   localparam int GROUPS = efv_pkg::TAP_COUNT / 3;

   efv_pkg::vel_type group_ff [GROUPS];
   efv_pkg::vel_type group_in [GROUPS];
   efv_pkg::vel_type sum_ff, sum_in;

   // Add the products three at a time
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = prod_in[3*g] + prod_in[3*g+1] + prod_in[3*g+2];
      end
   end

   // Add the group sums
   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_group) begin
         group_ff <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_final) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

/* hdl/encoder_fir_velocity_filter_core.sv */
// Top level of the encoder FIR velocity filter.
`timescale 1ns / 1ps
//
// Usage:
//   req_chan carries one signed encoder count per transfer (valid/ready).
//   rsp_chan returns, for each count, the count itself as position and the
//   nine-tap differentiator sum of the count history as velocity.
//   An input transfer sets valid1_ff with the products; valid2_ff follows
//   with the group sums, then valid3_ff, which is rsp_chan.valid, with the sum.
//   The tap cells register their products, then two adder stages follow.
//   Unstalled throughput is one count per cycle; each stage has its own
//   valid bit, so bubbles close up and a new count is taken while a result
//   still waits. When the receiver holds rsp_chan.ready low, the full
//   pipeline backs up, req_chan.ready drops; nothing is lost or repeated.
//   Reset clears the history and all valid bits. An all-zero history counts
//   as empty: the next count fills every entry, so the first velocity is 0.
//   The sum wraps to 37 bits, which only matters for counts above 24 bits.
//
module encoder_fir_velocity_filter_core #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic     clock,
   input  logic     reset,
   efv_req_if.sink  req_chan,
   efv_rsp_if.source rsp_chan
);

   localparam int TAPS = efv_pkg::TAP_COUNT;

   // Pipeline valid bits and per-stage ready
   logic valid1_ff, valid2_ff, valid3_ff;
   logic rdy1, rdy2, rdy3;
   logic req_xfer;

   logic signed [COUNT_WIDTH-1:0] pos1_ff, pos2_ff, pos3_ff;
   logic signed [COUNT_WIDTH-1:0] hist [TAPS];
   logic signed [COUNT_WIDTH-1:0] link [TAPS];
   efv_pkg::vel_type              prod [TAPS];
   efv_pkg::vel_type              vel_sum;
   logic [TAPS-1:0]               nonzero;

   efv_pkg::cell_ctrl_type cell_ctrl;
   efv_pkg::tree_ctrl_type tree_ctrl;

   // Advance a stage when it is empty or the next one advances
   assign rdy3     = !valid3_ff || rsp_chan.ready;
   assign rdy2     = !valid2_ff || rdy3;
   assign rdy1     = !valid1_ff || rdy2;
   assign req_xfer = req_chan.valid && rdy1;

   assign req_chan.ready = rdy1;

   // Detect an empty history
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         nonzero[i] = |hist[i];
      end
   end

   assign cell_ctrl.load  = req_xfer;
   assign cell_ctrl.prime = !(|nonzero);

   assign tree_ctrl.adv_group = rdy2 && valid1_ff;
   assign tree_ctrl.adv_final = rdy3 && valid2_ff;

   // Row of history cells, newest first; each takes its neighbor's entry
   genvar t;
   generate
      for (t = 0; t < TAPS; t++) begin : g_cell
         if (t == 0) begin : g_head
            assign link[t] = req_chan.encoder_count;
         end else begin : g_body
            assign link[t] = hist[t-1];
         end
         efv_tap_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .COEF        (efv_pkg::TAP_COEF[t])
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (cell_ctrl),
            .count_in (req_chan.encoder_count),
            .link_in  (link[t]),
            .hist_out (hist[t]),
            .prod_out (prod[t])
         );
      end
   endgenerate

   efv_sum_tree u_tree (
      .clock   (clock),
      .ctrl    (tree_ctrl),
      .prod_in (prod),
      .sum_out (vel_sum)
   );

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            valid1_ff <= req_xfer;
         end
         if (rdy2) begin
            valid2_ff <= valid1_ff;
         end
         if (rdy3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   // Carry the position alongside the sum
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pos1_ff <= req_chan.encoder_count;
      end
      if (tree_ctrl.adv_group) begin
         pos2_ff <= pos1_ff;
      end
      if (tree_ctrl.adv_final) begin
         pos3_ff <= pos2_ff;
      end
   end

   assign rsp_chan.valid          = valid3_ff;
   assign rsp_chan.position_count = pos3_ff;
   assign rsp_chan.velocity_sum   = vel_sum;

endmodule
